// ----- design/soc_pkg.sv -----
// Shared types and constants for the servo output channel.
package soc_pkg;

   localparam int unsigned FAILSAFE_TIMEOUT_MS_DEF = 1000;
   localparam int unsigned ELAPSED_W = 11;

   // configuration register indexes
   localparam logic [2:0] CSR_OUTPUT_MODE     = 3'd0;
   localparam logic [2:0] CSR_INVERSION       = 3'd1;
   localparam logic [2:0] CSR_NARROW_SHIFT    = 3'd2;
   localparam logic [2:0] CSR_FAILSAFE_MODE   = 3'd3;
   localparam logic [2:0] CSR_FAILSAFE_OFFSET = 3'd4;
   localparam logic [2:0] CSR_LIMIT_MIN       = 3'd5;
   localparam logic [2:0] CSR_LIMIT_CENTER    = 3'd6;
   localparam logic [2:0] CSR_LIMIT_MAX       = 3'd7;

   localparam logic [1:0] MODE_LEVEL = 2'd0;
   localparam logic [1:0] MODE_PULSE = 2'd1;
   localparam logic [1:0] MODE_DUTY  = 2'd2;

   localparam logic [1:0] FS_SET_POS   = 2'd0;
   localparam logic [1:0] FS_NO_PULSES = 2'd1;

   localparam logic [15:0] US_MID     = 16'd1500;
   localparam logic [15:0] US_FULL    = 16'd3000;
   localparam logic [15:0] US_LOW     = 16'd988;
   localparam logic [15:0] US_HIGH    = 16'd2012;
   localparam logic [15:0] DUTY_LOW   = 16'd1000;
   localparam logic [15:0] DUTY_HIGH  = 16'd2000;
   localparam logic [11:0] DUTY_SPAN  = 12'd1000;

   typedef enum logic [1:0] {
      KIND_LEVEL = 2'd0,
      KIND_PULSE = 2'd1,
      KIND_DUTY  = 2'd2
   } soc_kind_type;

   typedef struct packed {
      logic [1:0]  output_mode;
      logic [1:0]  inversion;
      logic        narrow_shift;
      logic [1:0]  failsafe_mode;
      logic [9:0]  failsafe_offset;
      logic [11:0] limit_min;
      logic [11:0] limit_center;
      logic [11:0] limit_max;
   } soc_cfg_type;

   // word after mapping, ready for the write/failsafe stage
   typedef struct packed {
      logic         tick;
      logic         present;
      logic         lost;
      logic         fs_act;
      logic [15:0]  val;
      soc_kind_type kind;
      logic [11:0]  out_value;
      logic         pol;
   } soc_cand_type;

endpackage

// ----- design/servo_output_channel_unit.sv -----
// Servo output channel: top level with handshakes, channel state and result register.
// The result register is loaded from the input register through the shaping logic
// (limit multiply) and the change-detect. Throughput: one word per cycle while rsp_tready
// does not stall the result register; only a changed value makes a result word.
// Reset: synchronous, active high; clears valid flags, channel state and loads
// the configuration defaults.
module servo_output_channel_unit #(
   parameter int unsigned FAILSAFE_TIMEOUT_MS = soc_pkg::FAILSAFE_TIMEOUT_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] pulse_us, [12] value_present, [13] link_lost
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] out_value, [12] polarity_inverted
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [11:0] csr_wdata
);

   localparam int unsigned EW = soc_pkg::ELAPSED_W;
   localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};

   soc_pkg::soc_cfg_type  cfg_ff;
   soc_pkg::soc_cand_type cand;

   logic          s1_valid_ff;
   logic          s1_tick_ff;
   logic [11:0]   s1_us_ff;
   logic          s1_present_ff;
   logic          s1_lost_ff;
   logic          rsp_valid_ff;
   logic [11:0]   rsp_value_ff;
   logic          rsp_pol_ff;
   logic [1:0]    rsp_kind_ff;

   logic [15:0]   last_ff;
   logic [EW-1:0] elapsed_ff;
   logic          seen_ff;
   logic [EW-1:0] elapsed_in;
   logic          seen_in;
   logic          fire;
   logic          wr_req;
   logic          emit;
   logic          adv_o;

   assign adv_o      = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || adv_o;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_mode     <= soc_pkg::MODE_PULSE;
         cfg_ff.inversion       <= 2'd0;
         cfg_ff.narrow_shift    <= 1'b0;
         cfg_ff.failsafe_mode   <= soc_pkg::FS_SET_POS;
         cfg_ff.failsafe_offset <= 10'd512;
         cfg_ff.limit_min       <= 12'd988;
         cfg_ff.limit_center    <= 12'd1500;
         cfg_ff.limit_max       <= 12'd2012;
      end else if (csr_we) begin
         unique case (csr_addr)
            soc_pkg::CSR_OUTPUT_MODE:     cfg_ff.output_mode     <= csr_wdata[1:0];
            soc_pkg::CSR_INVERSION:       cfg_ff.inversion       <= csr_wdata[1:0];
            soc_pkg::CSR_NARROW_SHIFT:    cfg_ff.narrow_shift    <= csr_wdata[0];
            soc_pkg::CSR_FAILSAFE_MODE:   cfg_ff.failsafe_mode   <= csr_wdata[1:0];
            soc_pkg::CSR_FAILSAFE_OFFSET: cfg_ff.failsafe_offset <= csr_wdata[9:0];
            soc_pkg::CSR_LIMIT_MIN:       cfg_ff.limit_min       <= csr_wdata;
            soc_pkg::CSR_LIMIT_CENTER:    cfg_ff.limit_center    <= csr_wdata;
            soc_pkg::CSR_LIMIT_MAX:       cfg_ff.limit_max       <= csr_wdata;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_tick_ff    <= req_tuser;
         s1_us_ff      <= req_tdata[11:0];
         s1_present_ff <= req_tdata[12];
         s1_lost_ff    <= req_tdata[13];
      end
   end

   soc_shape u_shape (
      .cfg      (cfg_ff),
      .tick     (s1_tick_ff),
      .pulse_us (s1_us_ff),
      .present  (s1_present_ff),
      .lost     (s1_lost_ff),
      .cand     (cand)
   );

   // channel state: failsafe timer and change detect
   always_comb begin
      elapsed_in = elapsed_ff;
      seen_in    = seen_ff;
      fire       = 1'b0;
      if (!cand.tick) begin
         elapsed_in = '0;
         seen_in    = 1'b1;
         wr_req     = cand.present;
      end else begin
         if (elapsed_ff != ELAPSED_MAX) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
         fire = seen_ff && (cand.lost || (elapsed_in > EW'(FAILSAFE_TIMEOUT_MS)));
         if (fire) begin
            seen_in = 1'b0;
         end
         wr_req = fire && cand.fs_act;
      end
      emit = wr_req && (cand.val != last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= 16'hFFFF;
         elapsed_ff <= '0;
         seen_ff    <= 1'b0;
      end else if (s1_valid_ff && adv_o) begin
         elapsed_ff <= elapsed_in;
         seen_ff    <= seen_in;
         if (emit) begin
            last_ff <= cand.val;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_o) begin
         rsp_valid_ff <= s1_valid_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_o && s1_valid_ff && emit) begin
         rsp_value_ff <= cand.out_value;
         rsp_pol_ff   <= cand.pol;
         rsp_kind_ff  <= cand.kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_pol_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

// ----- design/soc_shape.sv -----
// Value shaping: inversion, limit mapping, failsafe position and result encoding.
module soc_shape (
   input  soc_pkg::soc_cfg_type  cfg,
   input  logic                  tick,
   input  logic [11:0]           pulse_us,
   input  logic                  present,
   input  logic                  lost,
   output soc_pkg::soc_cand_type cand
);

   logic [15:0]        inv_us;
   logic [10:0]        xc;
   logic               lower;
   logic [10:0]        dlt_w;
   logic [11:0]        base;
   logic [11:0]        top;
   logic signed [12:0] diff;
   logic signed [10:0] dlt_s;
   logic signed [23:0] prod;
   logic signed [23:0] prod_adj;
   logic signed [23:0] quo;
   logic [15:0]        mapped;
   logic [15:0]        val_word;
   logic [15:0]        fs_pos;
   logic [15:0]        v;
   logic               pol;
   logic [9:0]         duty;
   logic [11:0]        duty_out;

   always_comb begin
      inv_us = {4'd0, pulse_us};
      if (cfg.inversion[0]) begin
         inv_us = soc_pkg::US_FULL - {4'd0, pulse_us};
      end
   end

   // piecewise-linear limit mapping, one shared multiplier
   always_comb begin
      if (inv_us < soc_pkg::US_LOW) begin
         xc = soc_pkg::US_LOW[10:0];
      end else if (inv_us > soc_pkg::US_HIGH) begin
         xc = soc_pkg::US_HIGH[10:0];
      end else begin
         xc = inv_us[10:0];
      end
      lower = (xc <= soc_pkg::US_MID[10:0]);
      dlt_w = lower ? (xc - soc_pkg::US_LOW[10:0]) : (xc - soc_pkg::US_MID[10:0]);
      base  = lower ? cfg.limit_min : cfg.limit_center;
      top   = lower ? cfg.limit_center : cfg.limit_max;
      diff  = $signed({1'b0, top}) - $signed({1'b0, base});
      dlt_s = $signed({1'b0, dlt_w[9:0]});
      prod  = 24'(dlt_s) * 24'(diff);
      // divide by 512, truncating toward zero
      prod_adj = prod + (prod[23] ? 24'sd511 : 24'sd0);
      quo      = prod_adj >>> 9;
      mapped   = {4'd0, base} + quo[15:0];
   end

   always_comb begin
      if (cfg.output_mode == soc_pkg::MODE_LEVEL || cfg.output_mode == soc_pkg::MODE_DUTY) begin
         val_word = inv_us;
      end else begin
         val_word = mapped;
      end
      fs_pos = {6'd0, cfg.failsafe_offset} + soc_pkg::US_LOW;
      if (cfg.inversion[0]) begin
         fs_pos = soc_pkg::US_FULL - fs_pos;
      end
      if (!tick) begin
         v = val_word;
      end else if (cfg.failsafe_mode == soc_pkg::FS_SET_POS) begin
         v = fs_pos;
      end else begin
         v = 16'd0;
      end
   end

   // encoding of the word that would be emitted
   always_comb begin
      pol = cfg.inversion[1];
      if (v < soc_pkg::DUTY_LOW) begin
         duty = 10'd0;
      end else if (v > soc_pkg::DUTY_HIGH) begin
         duty = soc_pkg::DUTY_SPAN[9:0];
      end else begin
         duty = 10'(v - soc_pkg::DUTY_LOW);
      end
      duty_out = pol ? (soc_pkg::DUTY_SPAN - {2'd0, duty}) : {2'd0, duty};

      cand.tick    = tick;
      cand.present = present;
      cand.lost    = lost;
      cand.fs_act  = (cfg.failsafe_mode == soc_pkg::FS_SET_POS) ||
                     (cfg.failsafe_mode == soc_pkg::FS_NO_PULSES);
      cand.val     = v;
      unique case (cfg.output_mode)
         soc_pkg::MODE_LEVEL: begin
            cand.kind      = soc_pkg::KIND_LEVEL;
            cand.out_value = {11'd0, (v > soc_pkg::US_MID) ^ pol};
            cand.pol       = 1'b0;
         end
         soc_pkg::MODE_DUTY: begin
            cand.kind      = soc_pkg::KIND_DUTY;
            cand.out_value = duty_out;
            cand.pol       = 1'b0;
         end
         default: begin
            cand.kind      = soc_pkg::KIND_PULSE;
            cand.out_value = cfg.narrow_shift ? v[12:1] : v[11:0];
            cand.pol       = pol;
         end
      endcase
   end

endmodule

// ----- tb/servo_output_channel_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the servo output channel: random words, own predictor, stalls.
module servo_output_channel_unit_tb;

   localparam int unsigned FAILSAFE_TIMEOUT_MS = soc_pkg::FAILSAFE_TIMEOUT_MS_DEF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 300;
   localparam int MAP_SPAN     = int'(soc_pkg::US_MID - soc_pkg::US_LOW);

   localparam logic       OP_VALUE       = 1'b0;
   localparam logic       OP_TICK        = 1'b1;
   localparam logic [1:0] MODE_PULSE_ALT = 2'd3;
   localparam logic [1:0] FS_HOLD        = 2'd2;
   localparam logic [1:0] FS_HOLD_ALT    = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [11:0] us;
      logic        present;
      logic        lost;
   } channel_word_type;

   typedef struct packed {
      soc_pkg::soc_kind_type kind;
      logic [11:0]           value;
      logic                  pol;
   } servo_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [11:0] csr_wdata = '0;

   servo_output_channel_unit #(
      .FAILSAFE_TIMEOUT_MS(FAILSAFE_TIMEOUT_MS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   channel_word_type channel_words[$];
   servo_write_type  servo_writes_due[$];

   // channel mirror
   soc_pkg::soc_cfg_type cfg;
   logic [15:0] last_written = 16'hFFFF;
   logic [10:0] elapsed_ms = '0;
   logic        fs_armed = 1'b0;

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int          req_gap_max = 0;
   int          req_gap_left = 0;
   int          rsp_gap_max = 0;
   int          rsp_stall_left = 0;
   logic        long_hold_go = 1'b0;
   int          hold_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   logic [11:0] recent_us = 12'd1500;

   function automatic logic [15:0] limit_map(logic [15:0] v);
      int x, lo, mid, hi, r;
      x   = int'(v);
      lo  = int'(cfg.limit_min);
      mid = int'(cfg.limit_center);
      hi  = int'(cfg.limit_max);
      if (x < int'(soc_pkg::US_LOW)) x = int'(soc_pkg::US_LOW);
      if (x > int'(soc_pkg::US_HIGH)) x = int'(soc_pkg::US_HIGH);
      if (x <= int'(soc_pkg::US_MID))
         r = lo + ((x - int'(soc_pkg::US_LOW)) * (mid - lo)) / MAP_SPAN;
      else
         r = mid + ((x - int'(soc_pkg::US_MID)) * (hi - mid)) / MAP_SPAN;
      return 16'(r);
   endfunction

   // only a change of value leaves the channel
   task automatic emit_servo_write(logic [15:0] v);
      servo_write_type w;
      logic [15:0]     d;
      logic            pol;
      pol = cfg.inversion[1];
      if (v != last_written) begin
         last_written = v;
         case (cfg.output_mode)
            soc_pkg::MODE_LEVEL: begin
               w.kind  = soc_pkg::KIND_LEVEL;
               w.value = {11'd0, (v > soc_pkg::US_MID) ^ pol};
               w.pol   = 1'b0;
            end
            soc_pkg::MODE_DUTY: begin
               d = v;
               if (d < soc_pkg::DUTY_LOW) d = soc_pkg::DUTY_LOW;
               if (d > soc_pkg::DUTY_HIGH) d = soc_pkg::DUTY_HIGH;
               d = d - soc_pkg::DUTY_LOW;
               if (pol) d = {4'd0, soc_pkg::DUTY_SPAN} - d;
               w.kind  = soc_pkg::KIND_DUTY;
               w.value = d[11:0];
               w.pol   = 1'b0;
            end
            default: begin
               d = cfg.narrow_shift ? (v >> 1) : v;
               w.kind  = soc_pkg::KIND_PULSE;
               w.value = d[11:0];
               w.pol   = pol;
            end
         endcase
         servo_writes_due.push_back(w);
      end
   endtask

   task automatic advance_channel(logic opcode, logic [11:0] us, logic present, logic lost);
      logic [15:0] v;
      if (opcode == OP_VALUE) begin
         fs_armed   = 1'b1;
         elapsed_ms = '0;
         if (present) begin
            v = {4'd0, us};
            if (cfg.inversion[0]) v = soc_pkg::US_FULL - v;
            if (cfg.output_mode != soc_pkg::MODE_LEVEL &&
                cfg.output_mode != soc_pkg::MODE_DUTY)
               v = limit_map(v);
            emit_servo_write(v);
         end
      end else begin
         if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
         if (fs_armed && (lost || elapsed_ms > FAILSAFE_TIMEOUT_MS)) begin
            fs_armed = 1'b0;
            if (cfg.failsafe_mode == soc_pkg::FS_SET_POS) begin
               v = {6'd0, cfg.failsafe_offset} + soc_pkg::US_LOW;
               if (cfg.inversion[0]) v = soc_pkg::US_FULL - v;
               emit_servo_write(v);
            end else if (cfg.failsafe_mode == soc_pkg::FS_NO_PULSES) begin
               emit_servo_write(16'd0);
            end
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      servo_write_type due;
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready)
         advance_channel(req_tuser, req_tdata[11:0], req_tdata[12], req_tdata[13]);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (servo_writes_due.size() == 0) begin
            $error("result word with nothing expected: kind %0d value %0d",
                   rsp_tuser, rsp_tdata[11:0]);
            mismatches++;
         end else begin
            due = servo_writes_due.pop_front();
            if (rsp_tuser !== due.kind) begin
               $error("out_kind: expected %0d, got %0d", due.kind, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[11:0] !== due.value) begin
               $error("out_value: expected %0d, got %0d", due.value, rsp_tdata[11:0]);
               mismatches++;
            end
            if (rsp_tdata[12] !== due.pol) begin
               $error("polarity_inverted: expected %0d, got %0d", due.pol, rsp_tdata[12]);
               mismatches++;
            end
         end
      end
   end

   always @(negedge clock) begin : sender
      channel_word_type w;
      // hold the word until it has been taken
      if (!(req_tvalid && !req_taken)) begin
         if (req_gap_left != 0) begin
            req_tvalid   <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (channel_words.size() != 0) begin
            w = channel_words.pop_front();
            req_tvalid   <= 1'b1;
            req_tuser    <= w.opcode;
            req_tdata    <= {2'b00, w.lost, w.present, w.us};
            req_gap_left <= $urandom_range(0, req_gap_max);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      int stall;
      if (long_hold_go && hold_count < LONG_HOLD) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         if (!long_hold_go) hold_count <= 0;
         if (rsp_taken && rsp_gap_max != 0) begin
            stall = $urandom_range(0, rsp_gap_max);
            rsp_tready     <= (stall == 0);
            rsp_stall_left <= (stall == 0) ? 0 : stall - 1;
         end else if (rsp_stall_left != 0) begin
            rsp_tready     <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void push_value(logic [11:0] us, logic present);
      channel_words.push_back('{OP_VALUE, us, present, 1'($urandom_range(0, 1))});
   endfunction

   function automatic void push_tick(logic lost);
      channel_words.push_back('{OP_TICK, 12'($urandom_range(0, 4095)),
                                1'($urandom_range(0, 1)), lost});
   endfunction

   function automatic void push_random_word();
      int pick;
      logic [11:0] us;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: us = 12'($urandom_range(950, 2050));
            4, 5, 6:    us = 12'($urandom_range(0, 3000));
            7, 8:       us = 12'($urandom_range(0, 4095));
            default:    us = recent_us;
         endcase
         recent_us = us;
         push_value(us, 1'b1);
      end else if (pick < 63) begin
         push_value(12'($urandom_range(0, 4095)), 1'b0);
      end else begin
         push_tick(pick >= 93);
      end
   endfunction

   function automatic logic [11:0] pick_limit();
      case ($urandom_range(0, 15))
         0:       return 12'd0;
         1:       return 12'd3000;
         2:       return 12'hFFF;
         default: return 12'($urandom_range(0, 3000));
      endcase
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [11:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         soc_pkg::CSR_OUTPUT_MODE:     cfg.output_mode     = val[1:0];
         soc_pkg::CSR_INVERSION:       cfg.inversion       = val[1:0];
         soc_pkg::CSR_NARROW_SHIFT:    cfg.narrow_shift    = val[0];
         soc_pkg::CSR_FAILSAFE_MODE:   cfg.failsafe_mode   = val[1:0];
         soc_pkg::CSR_FAILSAFE_OFFSET: cfg.failsafe_offset = val[9:0];
         soc_pkg::CSR_LIMIT_MIN:       cfg.limit_min       = val;
         soc_pkg::CSR_LIMIT_CENTER:    cfg.limit_center    = val;
         soc_pkg::CSR_LIMIT_MAX:       cfg.limit_max       = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [1:0] mode, logic [1:0] inv, logic narrow,
                                 logic [1:0] fs_mode, logic [9:0] fs_offset,
                                 logic [11:0] lo, logic [11:0] mid, logic [11:0] hi);
      csr_write(soc_pkg::CSR_OUTPUT_MODE, {10'd0, mode});
      csr_write(soc_pkg::CSR_INVERSION, {10'd0, inv});
      csr_write(soc_pkg::CSR_NARROW_SHIFT, {11'd0, narrow});
      csr_write(soc_pkg::CSR_FAILSAFE_MODE, {10'd0, fs_mode});
      csr_write(soc_pkg::CSR_FAILSAFE_OFFSET, {2'd0, fs_offset});
      csr_write(soc_pkg::CSR_LIMIT_MIN, lo);
      csr_write(soc_pkg::CSR_LIMIT_CENTER, mid);
      csr_write(soc_pkg::CSR_LIMIT_MAX, hi);
   endtask

   // channel empty, nothing owed, then let any word without a result drain out
   task automatic wait_idle();
      while (channel_words.size() != 0 || req_tvalid || servo_writes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int phase;
      cfg.output_mode     = soc_pkg::MODE_PULSE;
      cfg.inversion       = 2'd0;
      cfg.narrow_shift    = 1'b0;
      cfg.failsafe_mode   = soc_pkg::FS_SET_POS;
      cfg.failsafe_offset = 10'd512;
      cfg.limit_min       = 12'd988;
      cfg.limit_center    = 12'd1500;
      cfg.limit_max       = 12'd2012;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      req_gap_max = 2;
      rsp_gap_max = 2;

      // reset settings: repeat, clamps, missing value, link-lost failsafe
      push_value(12'd1500, 1'b1);
      push_value(12'd1500, 1'b1);
      push_value(12'd0, 1'b1);
      push_value(12'hFFF, 1'b1);
      push_value(12'd700, 1'b0);
      push_tick(1'b1);
      wait_idle();

      // level output, both inversions, failsafe writes zero
      apply_settings(soc_pkg::MODE_LEVEL, 2'd3, 1'b0, soc_pkg::FS_NO_PULSES, 10'd512,
                     12'd988, 12'd1500, 12'd2012);
      push_value(12'd1500, 1'b1);
      push_value(12'd1501, 1'b1);
      push_value(12'hFFF, 1'b1);
      push_tick(1'b1);
      wait_idle();

      // duty output with polarity flip, failsafe holds
      apply_settings(soc_pkg::MODE_DUTY, 2'd2, 1'b0, FS_HOLD, 10'd512,
                     12'd988, 12'd1500, 12'd2012);
      push_value(12'd999, 1'b1);
      push_value(12'd2001, 1'b1);
      push_value(12'd1500, 1'b1);
      push_tick(1'b1);
      push_value(12'd1000, 1'b1);
      wait_idle();

      // spare pulse mode code, narrow pulses, inverted value wrapping, extreme limits
      apply_settings(MODE_PULSE_ALT, 2'd1, 1'b1, FS_HOLD_ALT, 10'd1023,
                     12'd3000, 12'd0, 12'd3000);
      push_value(12'd0, 1'b1);
      push_value(12'd1500, 1'b1);
      push_value(12'd3001, 1'b1);
      push_tick(1'b1);
      wait_idle();

      // failsafe position bypasses the mapping
      apply_settings(soc_pkg::MODE_PULSE, 2'd1, 1'b0, soc_pkg::FS_SET_POS, 10'd0,
                     12'hFFF, 12'hFFF, 12'd0);
      push_value(12'd988, 1'b1);
      push_value(12'd1700, 1'b1);
      push_tick(1'b1);
      push_tick(1'b1);
      wait_idle();

      for (phase = 0; phase < 14; phase++) begin
         case (phase % 3)
            0: begin
               req_gap_max = 0;
               rsp_gap_max = 0;
            end
            1: begin
               req_gap_max = 4;
               rsp_gap_max = 4;
            end
            default: begin
               req_gap_max = $urandom_range(0, 1) * 4;
               rsp_gap_max = $urandom_range(0, 1) * 4;
            end
         endcase
         if (phase == 4) begin
            // receiver stalls long enough for the pipeline to back up
            apply_settings(soc_pkg::MODE_PULSE, 2'd0, 1'b0, soc_pkg::FS_SET_POS, 10'd512,
                           12'd988, 12'd1500, 12'd2012);
            req_gap_max = 0;
            @(posedge clock);
            long_hold_go = 1'b1;
            for (int i = 0; i < 16; i++) push_value(12'(1000 + 13 * i), 1'b1);
            while (hold_count < LONG_HOLD) @(posedge clock);
            long_hold_go = 1'b0;
            wait_idle();
         end
         apply_settings(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                        10'($urandom_range(0, 1023)),
                        pick_limit(), pick_limit(), pick_limit());
         if (phase == 9) begin
            // silence past the timeout
            push_value(12'd1234, 1'b1);
            repeat (FAILSAFE_TIMEOUT_MS + 3) push_tick(1'b0);
         end
         repeat (5) push_random_word();
         wait_idle();
      end

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
design/soc_pkg.sv
design/soc_shape.sv
design/servo_output_channel_unit.sv
tb/servo_output_channel_unit_tb.sv
